@@ design/fgn_pkg.sv @@
package fgn_pkg;

  localparam int TABLE_SIZE      = 256;
  localparam int TBL_AW          = $clog2(TABLE_SIZE);
  localparam int MAX_OCTAVES_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;
  localparam int G_W             = 21;

  localparam logic [7:0] CFG_OCTAVE_COUNT     = 8'd0;
  localparam logic [7:0] CFG_BASE_FREQUENCY   = 8'd1;
  localparam logic [7:0] CFG_PERSISTENCE_GAIN = 8'd2;
  localparam logic [7:0] CFG_LACUNARITY_GAIN  = 8'd3;

  localparam logic [4:0]  OCTAVE_COUNT_RST   = 5'd1;
  localparam logic [31:0] BASE_FREQUENCY_RST = 32'h1000_0000;
  localparam logic [15:0] PERSISTENCE_RST    = 16'd8192;
  localparam logic [15:0] LACUNARITY_RST     = 16'd8192;

  localparam logic [31:0] AMP_ONE   = 32'h0001_0000;
  localparam logic [36:0] FADE_TEN  = 37'h0A_0000_0000;

  typedef struct packed {
    logic                    is_sample;
    logic [TBL_AW-1:0]       table_index;
    logic [7:0]              table_value;
    logic signed [31:0]      world_x;
    logic signed [31:0]      world_y;
  } item_t;

  typedef struct packed {
    logic [4:0]  octave_count;
    logic [31:0] base_frequency;
    logic [15:0] persistence_gain;
    logic [15:0] lacunarity_gain;
  } cfg_t;

  function automatic logic signed [G_W-1:0] grad_f(logic [3:0] h,
                                                  logic signed [17:0] x,
                                                  logic signed [17:0] y);
    logic signed [G_W-1:0] u;
    logic signed [G_W-1:0] v;
    u = (h < 4'd8) ? G_W'(x) : G_W'(y);
    if (h < 4'd4) begin
      v = G_W'(y);
    end else if (h == 4'd12 || h == 4'd14) begin
      v = G_W'(x);
    end else begin
      v = '0;
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage

@@ design/fgn_if.sv @@
interface fgn_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [7:0]         table_index;
  logic [7:0]         table_value;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  modport source(output valid, mode, table_index, table_value, world_x, world_y,
                 input ready);
  modport sink(input valid, mode, table_index, table_value, world_x, world_y,
               output ready);
endinterface

interface fgn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_value;
  modport source(output valid, noise_value, input ready);
  modport sink(input valid, noise_value, output ready);
endinterface

interface fgn_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ design/fgn_front.sv @@
module fgn_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  fgn_in_if.sink        in_i,
  output logic          deq_valid_o,
  input  logic          deq_ready_i,
  output fgn_pkg::item_t deq_item_o
);
  import fgn_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t         mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   count_q, count_d;
  logic          push, pop;
  item_t         item;

  assign in_i.ready  = (count_q != (PW+1)'(QUEUE_DEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign deq_valid_o = (count_q != '0);
  assign pop         = deq_valid_o && deq_ready_i;
  assign deq_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    item.is_sample   = in_i.mode;
    item.table_index = in_i.table_index;
    item.table_value = in_i.table_value;
    item.world_x     = in_i.world_x;
    item.world_y     = in_i.world_y;
    wr_ptr_d = push ? PW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? PW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PW+1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

@@ design/fgn_core.sv @@
module fgn_core #(
  parameter int MAX_OCTAVES = fgn_pkg::MAX_OCTAVES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fgn_pkg::cfg_t  cfg_i,
  input  logic           deq_valid_i,
  output logic           deq_ready_o,
  input  fgn_pkg::item_t deq_item_i,
  fgn_out_if.source      out_o
);
  import fgn_pkg::*;

  localparam int CNT_W = $clog2(MAX_OCTAVES + 1);
  localparam int TOT_W = 33 + $clog2(MAX_OCTAVES);
  localparam int SUM_W = 54 + $clog2(MAX_OCTAVES);
  localparam int DC_W  = $clog2(SUM_W);
  localparam int REM_W = TOT_W + 2;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MX    = 4'd1;
  localparam logic [3:0] ST_MY    = 4'd2;
  localparam logic [3:0] ST_READ  = 4'd3;
  localparam logic [3:0] ST_FT2   = 4'd4;
  localparam logic [3:0] ST_FT3   = 4'd5;
  localparam logic [3:0] ST_FMUL  = 4'd6;
  localparam logic [3:0] ST_GRAD  = 4'd7;
  localparam logic [3:0] ST_LERP1 = 4'd8;
  localparam logic [3:0] ST_LERP2 = 4'd9;
  localparam logic [3:0] ST_ACC   = 4'd10;
  localparam logic [3:0] ST_DPREP = 4'd11;
  localparam logic [3:0] ST_DIV   = 4'd12;
  localparam logic [3:0] ST_OUT   = 4'd13;

  function automatic logic signed [G_W-1:0] lerp_f(logic [16:0] t,
                                                  logic signed [G_W-1:0] a,
                                                  logic signed [G_W-1:0] b);
    logic signed [G_W:0]    d;
    logic signed [G_W+18:0] pr;
    d  = (G_W+1)'(b) - (G_W+1)'(a);
    pr = $signed({1'b0, t}) * d;
    return a + G_W'(pr >>> 16);
  endfunction

  logic [3:0]              state_q, state_d;
  logic [CNT_W-1:0]        oct_q, oct_d, n_q, n_d;
  logic [3:0]              step_q, step_d;
  logic [DC_W-1:0]         dcnt_q, dcnt_d;
  logic signed [31:0]      wx_q, wx_d, wy_q, wy_d;
  logic [31:0]             freq_q, freq_d, amp_q, amp_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [TOT_W-1:0]        total_q, total_d;
  logic [7:0]              cx_q, cx_d, cy_q, cy_d;
  logic [15:0]             fx_q, fx_d, fy_q, fy_d;
  logic [7:0]              a_q, a_d, b_q, b_d;
  logic [7:0]              h_q [4];
  logic [7:0]              h_d [4];
  logic [3:0]              k_q [4];
  logic [3:0]              k_d [4];
  logic [31:0]             t2x_q, t2x_d, t2y_q, t2y_d;
  logic [47:0]             t3x_q, t3x_d, t3y_q, t3y_d;
  logic [36:0]             pfx_q, pfx_d, pfy_q, pfy_d;
  logic [16:0]             u_q, u_d, v_q, v_d;
  logic signed [G_W-1:0]   g_q [4];
  logic signed [G_W-1:0]   g_d [4];
  logic signed [G_W-1:0]   l0_q, l0_d, l1_q, l1_d, nz_q, nz_d;
  logic [REM_W-1:0]        rem_q, rem_d, rem_sh;
  logic [SUM_W-1:0]        quo_q, quo_d;
  logic [TOT_W:0]          dvs_q, dvs_d;
  logic                    neg_q, neg_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [15:0]      out_data_q, out_data_d;

  logic [7:0]              perm_mem [TABLE_SIZE];
  logic [7:0]              rdata_q;
  logic [TBL_AW-1:0]       raddr;
  logic                    we;

  logic signed [31:0]      mw;
  logic signed [64:0]      mprod;
  logic [52:0]             fpx, fpy;
  logic signed [53:0]      acc_prod;
  logic [47:0]             amp_prod, freq_prod;
  logic signed [15:0]      sat_val;
  logic                    out_load;
  logic                    in_oct;
  logic signed [17:0]      xa, xb, ya, yb;

  assign deq_ready_o       = (state_q == ST_IDLE);
  assign we                = deq_valid_i && deq_ready_o && !deq_item_i.is_sample;
  assign out_o.valid       = out_valid_q;
  assign out_o.noise_value = out_data_q;
  assign out_load          = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  always_comb begin
    unique case (step_q)
      4'd0:    raddr = cx_q;
      4'd1:    raddr = 8'(cx_q + 1'b1);
      4'd2:    raddr = a_q;
      4'd3:    raddr = b_q;
      4'd4:    raddr = 8'(a_q + 1'b1);
      4'd5:    raddr = 8'(b_q + 1'b1);
      4'd6:    raddr = h_q[0];
      4'd7:    raddr = h_q[1];
      4'd8:    raddr = h_q[2];
      4'd9:    raddr = h_q[3];
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      perm_mem[deq_item_i.table_index] <= deq_item_i.table_value;
    end
    rdata_q <= perm_mem[raddr];
  end

  always_comb begin
    mw        = (state_q == ST_MY) ? wy_q : wx_q;
    mprod     = mw * $signed({1'b0, freq_q});
    fpx       = t3x_q[47:16] * pfx_q[36:16];
    fpy       = t3y_q[47:16] * pfy_q[36:16];
    acc_prod  = nz_q * $signed({1'b0, amp_q});
    amp_prod  = amp_q * cfg_i.persistence_gain;
    freq_prod = freq_q * cfg_i.lacunarity_gain;
    rem_sh    = {rem_q[REM_W-2:0], quo_q[SUM_W-1]};
    xa        = $signed({2'b00, fx_q});
    xb        = $signed({2'b11, fx_q});
    ya        = $signed({2'b00, fy_q});
    yb        = $signed({2'b11, fy_q});
    if (neg_q) begin
      sat_val = (quo_q > SUM_W'(32768)) ? 16'sh8000 : 16'(-quo_q);
    end else begin
      sat_val = (quo_q > SUM_W'(32767)) ? 16'sh7FFF : 16'(quo_q);
    end
  end

  always_comb begin
    state_d = state_q;
    oct_d   = oct_q;
    n_d     = n_q;
    step_d  = step_q;
    dcnt_d  = dcnt_q;
    wx_d    = wx_q;
    wy_d    = wy_q;
    freq_d  = freq_q;
    amp_d   = amp_q;
    sum_d   = sum_q;
    total_d = total_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    fx_d    = fx_q;
    fy_d    = fy_q;
    a_d     = a_q;
    b_d     = b_q;
    h_d     = h_q;
    k_d     = k_q;
    t2x_d   = t2x_q;
    t2y_d   = t2y_q;
    t3x_d   = t3x_q;
    t3y_d   = t3y_q;
    pfx_d   = pfx_q;
    pfy_d   = pfy_q;
    u_d     = u_q;
    v_d     = v_q;
    g_d     = g_q;
    l0_d    = l0_q;
    l1_d    = l1_q;
    nz_d    = nz_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (deq_valid_i && deq_item_i.is_sample) begin
          wx_d    = deq_item_i.world_x;
          wy_d    = deq_item_i.world_y;
          freq_d  = cfg_i.base_frequency;
          amp_d   = AMP_ONE;
          sum_d   = '0;
          total_d = '0;
          oct_d   = '0;
          if ({27'd0, cfg_i.octave_count} > 32'(MAX_OCTAVES)) begin
            n_d = CNT_W'(MAX_OCTAVES);
          end else begin
            n_d = CNT_W'(cfg_i.octave_count);
          end
          if (cfg_i.octave_count == '0) begin
            quo_d   = '0;
            neg_d   = 1'b0;
            state_d = ST_OUT;
          end else begin
            state_d = ST_MX;
          end
        end
      end
      ST_MX: begin
        cx_d    = mprod[51:44];
        fx_d    = mprod[43:28];
        state_d = ST_MY;
      end
      ST_MY: begin
        cy_d    = mprod[51:44];
        fy_d    = mprod[43:28];
        step_d  = '0;
        state_d = ST_READ;
      end
      ST_READ: begin
        step_d = step_q + 1'b1;
        unique case (step_q)
          4'd1:    a_d = 8'(rdata_q + cy_q);
          4'd2:    b_d = 8'(rdata_q + cy_q);
          4'd3:    h_d[0] = rdata_q;
          4'd4:    h_d[1] = rdata_q;
          4'd5:    h_d[2] = rdata_q;
          4'd6:    h_d[3] = rdata_q;
          4'd7:    k_d[0] = rdata_q[3:0];
          4'd8:    k_d[1] = rdata_q[3:0];
          4'd9:    k_d[2] = rdata_q[3:0];
          4'd10:   k_d[3] = rdata_q[3:0];
          default: ;
        endcase
        if (step_q == 4'd10) begin
          step_d  = '0;
          state_d = ST_FT2;
        end
      end
      ST_FT2: begin
        t2x_d   = fx_q * fx_q;
        t2y_d   = fy_q * fy_q;
        state_d = ST_FT3;
      end
      ST_FT3: begin
        t3x_d   = t2x_q * fx_q;
        t3y_d   = t2y_q * fy_q;
        pfx_d   = (37'(t2x_q) * 37'd6) + FADE_TEN - ((37'(fx_q) * 37'd15) << 16);
        pfy_d   = (37'(t2y_q) * 37'd6) + FADE_TEN - ((37'(fy_q) * 37'd15) << 16);
        state_d = ST_FMUL;
      end
      ST_FMUL: begin
        u_d     = fpx[48:32];
        v_d     = fpy[48:32];
        state_d = ST_GRAD;
      end
      ST_GRAD: begin
        g_d[0]  = grad_f(k_q[0], xa, ya);
        g_d[1]  = grad_f(k_q[1], xb, ya);
        g_d[2]  = grad_f(k_q[2], xa, yb);
        g_d[3]  = grad_f(k_q[3], xb, yb);
        state_d = ST_LERP1;
      end
      ST_LERP1: begin
        l0_d    = lerp_f(u_q, g_q[0], g_q[1]);
        l1_d    = lerp_f(u_q, g_q[2], g_q[3]);
        state_d = ST_LERP2;
      end
      ST_LERP2: begin
        nz_d    = lerp_f(v_q, l0_q, l1_q);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        sum_d   = sum_q + SUM_W'(acc_prod);
        total_d = total_q + TOT_W'(amp_q);
        amp_d   = (amp_prod[47:46] != 2'b00) ? 32'hFFFF_FFFF : amp_prod[45:14];
        freq_d  = (freq_prod[47:44] != 4'h0) ? 32'hFFFF_FFFF : freq_prod[43:12];
        oct_d   = oct_q + 1'b1;
        state_d = (oct_d == n_q) ? ST_DPREP : ST_MX;
      end
      ST_DPREP: begin
        neg_d   = sum_q[SUM_W-1];
        quo_d   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
        rem_d   = '0;
        dvs_d   = {total_q, 1'b0};
        dcnt_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, dvs_q}) begin
          rem_d = rem_sh - {1'b0, dvs_q};
          quo_d = {quo_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[SUM_W-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DC_W'(SUM_W - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_data_d  = sat_val;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oct_q       <= '0;
      n_q         <= '0;
      step_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oct_q       <= oct_d;
      n_q         <= n_d;
      step_q      <= step_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wx_q       <= wx_d;
    wy_q       <= wy_d;
    freq_q     <= freq_d;
    amp_q      <= amp_d;
    sum_q      <= sum_d;
    total_q    <= total_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    fx_q       <= fx_d;
    fy_q       <= fy_d;
    a_q        <= a_d;
    b_q        <= b_d;
    h_q        <= h_d;
    k_q        <= k_d;
    t2x_q      <= t2x_d;
    t2y_q      <= t2y_d;
    t3x_q      <= t3x_d;
    t3y_q      <= t3y_d;
    pfx_q      <= pfx_d;
    pfy_q      <= pfy_d;
    u_q        <= u_d;
    v_q        <= v_d;
    g_q        <= g_d;
    l0_q       <= l0_d;
    l1_q       <= l1_d;
    nz_q       <= nz_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    dvs_q      <= dvs_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
  end

  assign in_oct = (state_q != ST_IDLE) && (state_q != ST_DPREP) &&
                  (state_q != ST_DIV) && (state_q != ST_OUT);

  a_oct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_oct |-> (oct_q < n_q))
    else $error("octave index beyond octave count");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (deq_valid_i && deq_ready_o) |-> (state_q == ST_IDLE))
    else $error("item taken while busy");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (dvs_q != '0))
    else $error("division by zero amplitude");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result not presented after load");

endmodule

@@ design/fractal_gradient_noise.sv @@
// A load transfer writes one table entry; the back end stays idle while it does so.
// A sample runs the table reads, fade and interpolation once per octave
// for N octaves, N being the clamped octave count, then the divider
// produces one quotient bit per cycle.
// A two-entry queue takes new transfers while the back end is busy, until it is full.
// Reset restores the register defaults; the table is undefined until loaded.
module fractal_gradient_noise #(
  parameter int MAX_OCTAVES = fgn_pkg::MAX_OCTAVES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fgn_cfg_if.sink   cfg_i,
  fgn_in_if.sink    in_i,
  fgn_out_if.source out_o
);
  import fgn_pkg::*;

  cfg_t  cfg_q, cfg_d;
  logic  deq_valid;
  logic  deq_ready;
  item_t deq_item;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_OCTAVE_COUNT:     cfg_d.octave_count     = cfg_i.data[4:0];
        CFG_BASE_FREQUENCY:   cfg_d.base_frequency   = cfg_i.data;
        CFG_PERSISTENCE_GAIN: cfg_d.persistence_gain = cfg_i.data[15:0];
        CFG_LACUNARITY_GAIN:  cfg_d.lacunarity_gain  = cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.octave_count     <= OCTAVE_COUNT_RST;
      cfg_q.base_frequency   <= BASE_FREQUENCY_RST;
      cfg_q.persistence_gain <= PERSISTENCE_RST;
      cfg_q.lacunarity_gain  <= LACUNARITY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fgn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .deq_valid_o (deq_valid),
    .deq_ready_i (deq_ready),
    .deq_item_o  (deq_item)
  );

  fgn_core #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .deq_valid_i (deq_valid),
    .deq_ready_o (deq_ready),
    .deq_item_i  (deq_item),
    .out_o       (out_o)
  );

endmodule

@@ dv/fgn_checker.sv @@
module fgn_checker (
  input  logic clk_i,
  input  logic rst_ni,
  fgn_cfg_if   cfg_mon,
  fgn_in_if    in_mon,
  fgn_out_if   out_mon,
  output int   mismatch_count_o,
  output int   pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fgn_pkg::*;

  cfg_t               noise_cfg;
  logic [7:0]         perm_tbl [TABLE_SIZE];
  logic signed [15:0] noise_expected [$];
  int                 mismatches;

  function automatic longint fade_q16(longint t);
    logic [63:0] tu;
    logic [63:0] t3;
    logic [63:0] p;
    tu = t;
    t3 = tu * tu * tu;
    p  = 64'd6 * tu * tu + (64'd10 << 32) - 64'd15 * tu * 64'd65536;
    return longint'(((t3 >> 16) * (p >> 16)) >> 32);
  endfunction

  function automatic longint lerp_q16(longint t, longint a, longint b);
    return a + ((t * (b - a)) >>> 16);
  endfunction

  function automatic longint grad_q16(logic [3:0] h, longint x, longint y);
    longint u;
    longint v;
    u = (h < 4'd8) ? x : y;
    if (h < 4'd4) begin
      v = y;
    end else if (h == 4'd12 || h == 4'd14) begin
      v = x;
    end else begin
      v = 0;
    end
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint octave_layer(logic [63:0] px, logic [63:0] py);
    logic [7:0] xi;
    logic [7:0] yi;
    logic [7:0] a;
    logic [7:0] b;
    longint     xf;
    longint     yf;
    longint     u;
    longint     v;
    longint     g00;
    longint     g10;
    longint     g01;
    longint     g11;
    xi  = px[51:44];
    yi  = py[51:44];
    xf  = longint'(px[43:28]);
    yf  = longint'(py[43:28]);
    u   = fade_q16(xf);
    v   = fade_q16(yf);
    a   = perm_tbl[xi] + yi;
    b   = perm_tbl[8'(xi + 8'd1)] + yi;
    g00 = grad_q16(perm_tbl[perm_tbl[a]][3:0], xf, yf);
    g10 = grad_q16(perm_tbl[perm_tbl[b]][3:0], xf - 65536, yf);
    g01 = grad_q16(perm_tbl[perm_tbl[8'(a + 8'd1)]][3:0], xf, yf - 65536);
    g11 = grad_q16(perm_tbl[perm_tbl[8'(b + 8'd1)]][3:0], xf - 65536, yf - 65536);
    return lerp_q16(v, lerp_q16(u, g00, g10), lerp_q16(u, g01, g11));
  endfunction

  function automatic logic signed [15:0] fbm_noise(logic signed [31:0] x,
                                                   logic signed [31:0] y);
    logic [63:0] wx;
    logic [63:0] wy;
    logic [63:0] freq;
    logic [63:0] amp;
    longint      sum;
    longint      total;
    longint      q;
    int          n;
    wx    = {{32{x[31]}}, x};
    wy    = {{32{y[31]}}, y};
    n     = (noise_cfg.octave_count > MAX_OCTAVES_DEF) ? MAX_OCTAVES_DEF
                                                       : noise_cfg.octave_count;
    freq  = noise_cfg.base_frequency;
    amp   = 64'd65536;
    sum   = 0;
    total = 0;
    for (int i = 0; i < n; i++) begin
      sum   += octave_layer(wx * freq, wy * freq) * longint'(amp);
      total += longint'(amp);
      amp    = (amp * noise_cfg.persistence_gain) >> 14;
      if (amp > 64'hFFFF_FFFF) amp = 64'hFFFF_FFFF;
      freq   = (freq * noise_cfg.lacunarity_gain) >> 12;
      if (freq > 64'hFFFF_FFFF) freq = 64'hFFFF_FFFF;
    end
    if (total > 0) begin
      q = sum / (2 * total);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
    end else begin
      q = 0;
    end
    return 16'(q);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [15:0] want;
    if (!rst_ni) begin
      noise_cfg.octave_count     <= OCTAVE_COUNT_RST;
      noise_cfg.base_frequency   <= BASE_FREQUENCY_RST;
      noise_cfg.persistence_gain <= PERSISTENCE_RST;
      noise_cfg.lacunarity_gain  <= LACUNARITY_RST;
      noise_expected.delete();
      mismatches = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (noise_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected noise_value %0d", $time, out_mon.noise_value);
        end else begin
          want = noise_expected.pop_front();
          if (out_mon.noise_value !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: noise_value expected %0d actual %0d", $time, want,
                       out_mon.noise_value);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.mode) begin
          noise_expected.push_back(fbm_noise(in_mon.world_x, in_mon.world_y));
        end else begin
          perm_tbl[in_mon.table_index] = in_mon.table_value;
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_OCTAVE_COUNT:     noise_cfg.octave_count     <= cfg_mon.data[4:0];
          CFG_BASE_FREQUENCY:   noise_cfg.base_frequency   <= cfg_mon.data;
          CFG_PERSISTENCE_GAIN: noise_cfg.persistence_gain <= cfg_mon.data[15:0];
          CFG_LACUNARITY_GAIN:  noise_cfg.lacunarity_gain  <= cfg_mon.data[15:0];
          default: ;
        endcase
      end
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= noise_expected.size();
  end

endmodule

@@ dv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fgn_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   mismatch_count;
  int   pending_count;
  int   burst_left;

  fgn_cfg_if cfg_ch ();
  fgn_in_if  in_ch ();
  fgn_out_if out_ch ();

  fractal_gradient_noise uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch.sink),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  fgn_checker noise_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_mon         (cfg_ch),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic offer(logic is_sample, logic [7:0] idx, logic [7:0] val,
                       logic [31:0] x, logic [31:0] y);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= is_sample;
    in_ch.table_index <= idx;
    in_ch.table_value <= val;
    in_ch.world_x     <= x;
    in_ch.world_y     <= y;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic cfg_write(logic [7:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      3: return {16'($urandom()), ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
      default: return 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
    endcase
  endfunction

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      int mode;
      int hold_done;
      int cycles;
      mode      = 0;
      hold_done = 0;
      cycles    = 0;
      forever begin
        @(negedge clk_i);
        cycles++;
        if (cycles % 50 == 0) mode = $urandom_range(0, 3);
        if (!hold_done && cycles > 5000 && pending_count >= 2) begin
          hold_done = 1;
          out_ch.ready <= 1'b0;
          repeat (3000) @(negedge clk_i);
        end
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    int          octave_sel [12] = '{1, 0, 2, 3, 16, 31, 4, 2, 1, 3, 5, 2};
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] freq_val;
    logic [15:0] pers_val;
    logic [15:0] lac_val;
    int          n_items;
    rst_ni            = 1'b0;
    burst_left        = 0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = 1'b0;
    in_ch.table_index = '0;
    in_ch.table_value = '0;
    in_ch.world_x     = '0;
    in_ch.world_y     = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_OCTAVE_COUNT;
    cfg_ch.data       = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < TABLE_SIZE; i++) begin
      offer(1'b0, 8'(i), (i == 0) ? 8'hFF : (i == 255) ? 8'h00 : 8'($urandom()),
            '0, '0);
    end
    offer(1'b1, '0, '0, 32'h0000_0000, 32'h0000_0000);
    offer(1'b1, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    offer(1'b1, '0, '0, 32'h8000_0000, 32'h8000_0000);
    offer(1'b1, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
    offer(1'b1, '0, '0, 32'hFFFF_FFFF, 32'h0000_FFFF);
    offer(1'b1, '0, '0, 32'h0000_8000, 32'hFFFF_8000);
    offer(1'b1, 8'hFF, 8'hFF, 32'h00FF_0000, 32'h0100_0000);
    for (int i = 0; i < 16; i++) begin
      offer(1'b1, '0, '0, {16'(i), 16'h4000}, {16'(i * 3), 16'hC000});
    end
    drain();

    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin
          freq_val = BASE_FREQUENCY_RST;
          pers_val = PERSISTENCE_RST;
          lac_val  = LACUNARITY_RST;
        end
        1: begin
          freq_val = 32'h0000_0000;
          pers_val = 16'hFFFF;
          lac_val  = 16'h0000;
        end
        2: begin
          freq_val = 32'hFFFF_FFFF;
          pers_val = 16'h0000;
          lac_val  = 16'hFFFF;
        end
        3: begin
          freq_val = $urandom();
          pers_val = 16'hFFFF;
          lac_val  = 16'h0000;
        end
        4: begin
          freq_val = 32'h0400_0000;
          pers_val = $urandom();
          lac_val  = $urandom();
        end
        5: begin
          freq_val = 32'h0040_0000;
          pers_val = 16'h2000;
          lac_val  = 16'h1000;
        end
        default: begin
          freq_val = $urandom_range(0, 1) ? $urandom()
                                          : $urandom_range(32'h0010_0000, 32'h4000_0000);
          pers_val = $urandom();
          lac_val  = $urandom();
        end
      endcase
      cfg_write(CFG_OCTAVE_COUNT, 32'(octave_sel[p]));
      cfg_write(CFG_BASE_FREQUENCY, freq_val);
      cfg_write(CFG_PERSISTENCE_GAIN, {16'($urandom()), pers_val});
      cfg_write(CFG_LACUNARITY_GAIN, {16'($urandom()), lac_val});
      n_items = (octave_sel[p] >= 16) ? 40 : 140;
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 99) < 15) begin
          offer(1'b0, 8'($urandom()), 8'($urandom()), $urandom(), $urandom());
        end else begin
          coord_x = pick_coord();
          coord_y = pick_coord();
          offer(1'b1, 8'($urandom()), 8'($urandom()), coord_x, coord_y);
        end
      end
      drain();
    end

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ fractal_gradient_noise.f @@
design/fgn_pkg.sv
design/fgn_if.sv
design/fgn_front.sv
design/fgn_core.sv
design/fractal_gradient_noise.sv
dv/fgn_checker.sv
dv/tb.sv
